FILE: hw/rtl/lsfs_pkg.sv
// Shared constants and types for the LED strip frame serializer.
package lsfs_pkg;

	localparam int MAX_LEDS   = 512;
	localparam int COUNT_W    = 10;
	localparam int COLOR_W    = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = COUNT_W;
	// Longest run for one word is 36 bytes, so a 6-bit byte index covers it.
	localparam int IDX_W      = 6;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_LED_COUNT = 1'd0;
	localparam cfg_idx_t REG_CHIP_MODE = 1'd1;

	localparam logic [7:0] HDR_A    = 8'h41;
	localparam logic [7:0] HDR_D    = 8'h64;
	localparam logic [7:0] HDR_A2   = 8'h61;
	localparam logic [7:0] HDR_SALT = 8'h55;
	localparam logic [7:0] LED_MARK = 8'hFF;

	localparam logic [IDX_W-1:0] HDR_LEN_PLAIN = 6'd6;
	localparam logic [IDX_W-1:0] HDR_LEN_CHIP  = 6'd10;
	localparam logic [IDX_W-1:0] TAIL_MIN      = 6'd4;

	// Position of a named byte inside the header (six bytes plain, ten in chip mode).
	typedef enum logic [3:0] {
		HB_A    = 4'd0,
		HB_D    = 4'd1,
		HB_A2   = 4'd2,
		HB_HI   = 4'd3,
		HB_LO   = 4'd4,
		HB_CHK  = 4'd5
	} hdr_byte_t;

endpackage

FILE: hw/rtl/lsfs_pix_if.sv
// Valid/ready channel carrying one LED color word.
interface lsfs_pix_if
	import lsfs_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] red;
	logic [COLOR_W-1:0] green;
	logic [COLOR_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: hw/rtl/lsfs_byte_if.sv
// Valid/ready channel carrying one serial frame byte with its markers.
interface lsfs_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_out;
	logic       run_last;
	logic       frame_end;

	modport source (output valid, output byte_out, output run_last, output frame_end,
		input ready);
	modport sink   (input valid, input byte_out, input run_last, input frame_end,
		output ready);
endinterface

FILE: hw/rtl/led_strip_frame_serializer_top.sv
// Top level of the LED strip frame serializer: color words in, frame bytes out.
//
//   channel  | dir | word
//   ---------+-----+---------------------------------------------
//   pixel    | in  | red, green, blue
//   stream   | out | byte_out, run_last, frame_end
//   cfg      | in  | cfg_we, cfg_index, cfg_data (write only)
//
// The output lane moves one byte per cycle while the sink is ready; a color word
// causes 3 bytes (plain) or 4 (chip mode) in mid-frame, plus 6 or 10 for the header
// on the first LED, plus max(ceil(N/16),4) tail bytes on the last LED in chip mode;
// at most 36. The next word is taken in the cycle its predecessor's last byte enters
// the output register. Reset clears the frame position and restores led_count to 1
// and plain mode.
module led_strip_frame_serializer_top
	import lsfs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	lsfs_pix_if.sink              pixel,
	lsfs_byte_if.source           stream,
	input  logic                  cfg_we,
	input  cfg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [COUNT_W-1:0] led_count_q;
	logic               chip_mode_q;
	logic [COUNT_W-1:0] led_pos_q;

	// Word being serialized.
	logic               valid_s1;
	logic               chip_s1;
	logic               last_s1;
	logic [7:0]         hi_s1;
	logic [7:0]         lo_s1;
	logic [COLOR_W-1:0] red_s1;
	logic [COLOR_W-1:0] green_s1;
	logic [COLOR_W-1:0] blue_s1;
	logic [IDX_W-1:0]   hdr_len_s1;
	logic [IDX_W-1:0]   last_idx_s1;
	logic [IDX_W-1:0]   idx_q;

	// Output register.
	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic               out_run_last_q;
	logic               out_frame_end_q;

	// Frame geometry from the registers as they stand.
	logic [COUNT_W-1:0] n_leds;
	logic [COUNT_W-1:0] hdr_count;
	logic               pos_is_last;
	logic [IDX_W-1:0]   tail_raw;
	logic [IDX_W-1:0]   tail_len;
	logic [IDX_W-1:0]   new_hdr_len;
	logic [IDX_W-1:0]   new_led_len;
	logic [IDX_W-1:0]   new_tail_len;
	logic               new_hdr;

	logic               accept;
	logic               issue;
	logic               at_last;
	logic [7:0]         sel_byte;
	logic [IDX_W-1:0]   led_off;
	logic [1:0]         led_sel;
	logic [3:0]         hdr_sel;

	always_comb begin
		if (led_count_q == '0) begin
			n_leds = COUNT_W'(1);
		end else if (32'(led_count_q) > MAX_LEDS) begin
			n_leds = COUNT_W'(MAX_LEDS);
		end else begin
			n_leds = led_count_q;
		end
		hdr_count    = chip_mode_q ? n_leds : n_leds - COUNT_W'(1);
		pos_is_last  = ({1'b0, led_pos_q} + (COUNT_W+1)'(1)) >= {1'b0, n_leds};
		tail_raw     = IDX_W'(({1'b0, n_leds} + (COUNT_W+1)'(15)) >> 4);
		tail_len     = (tail_raw < TAIL_MIN) ? TAIL_MIN : tail_raw;
		new_hdr      = (led_pos_q == '0);
		new_hdr_len  = new_hdr ? (chip_mode_q ? HDR_LEN_CHIP : HDR_LEN_PLAIN) : '0;
		new_led_len  = chip_mode_q ? IDX_W'(4) : IDX_W'(3);
		new_tail_len = (pos_is_last && chip_mode_q) ? tail_len : '0;
	end

	assign at_last      = (idx_q == last_idx_s1);
	assign issue        = valid_s1 && (!out_valid_q || stream.ready);
	assign pixel.ready  = !valid_s1 || (issue && at_last);
	assign accept       = pixel.valid && pixel.ready;

	// Byte selection by the index within the current run.
	always_comb begin
		hdr_sel = idx_q[3:0];
		led_off = idx_q - hdr_len_s1;
		// Plain mode skips the 0xFF marker slot.
		led_sel = chip_s1 ? led_off[1:0] : led_off[1:0] + 2'd1;
		sel_byte = '0;
		if (idx_q < hdr_len_s1) begin
			case (hdr_sel)
				HB_A:    sel_byte = HDR_A;
				HB_D:    sel_byte = HDR_D;
				HB_A2:   sel_byte = HDR_A2;
				HB_HI:   sel_byte = hi_s1;
				HB_LO:   sel_byte = lo_s1;
				HB_CHK:  sel_byte = hi_s1 ^ lo_s1 ^ HDR_SALT;
				default: sel_byte = '0;
			endcase
		end else if (led_off < (chip_s1 ? IDX_W'(4) : IDX_W'(3))) begin
			case (led_sel)
				2'd0:    sel_byte = LED_MARK;
				2'd1:    sel_byte = red_s1;
				2'd2:    sel_byte = green_s1;
				default: sel_byte = blue_s1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q <= COUNT_W'(1);
			chip_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LED_COUNT: led_count_q <= cfg_data[COUNT_W-1:0];
				REG_CHIP_MODE: chip_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_pos_q <= '0;
			valid_s1  <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (accept) begin
				led_pos_q <= pos_is_last ? '0 : led_pos_q + COUNT_W'(1);
				valid_s1  <= 1'b1;
				idx_q     <= '0;
			end else if (issue) begin
				if (at_last) begin
					valid_s1 <= 1'b0;
					idx_q    <= '0;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			chip_s1     <= chip_mode_q;
			last_s1     <= pos_is_last;
			hi_s1       <= 8'(hdr_count >> 8);
			lo_s1       <= hdr_count[7:0];
			red_s1      <= pixel.red;
			green_s1    <= pixel.green;
			blue_s1     <= pixel.blue;
			hdr_len_s1  <= new_hdr_len;
			last_idx_s1 <= new_hdr_len + new_led_len + new_tail_len - IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (issue) begin
			out_valid_q <= 1'b1;
		end else if (stream.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			out_byte_q      <= sel_byte;
			out_run_last_q  <= at_last;
			out_frame_end_q <= at_last && last_s1;
		end
	end

	assign stream.valid     = out_valid_q;
	assign stream.byte_out  = out_byte_q;
	assign stream.run_last  = out_run_last_q;
	assign stream.frame_end = out_frame_end_q;

endmodule

FILE: tb/sv/led_strip_frame_serializer_top_tb.sv
// Testbench for the LED strip frame serializer: directed and random color words, bytes checked.
module led_strip_frame_serializer_top_tb
	import lsfs_pkg::*;
;

	localparam int NUM_DIR     = 23;
	localparam int TOTAL_WORDS = 210;
	localparam int QUIET_TAIL  = 30;
	localparam int HOLD_AT     = 60;
	localparam int HOLD_CYCLES = 150;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} led_rgb_t;

	typedef struct packed {
		logic [7:0] data;
		logic       run_last;
		logic       frame_end;
	} frame_byte_t;

	// One directed step: optional register writes, then one color word. A nonzero
	// run length means the header bytes and run length below are known by hand.
	typedef struct packed {
		logic                  set_count;
		logic [CFG_DATA_W-1:0] count;
		logic                  set_chip;
		logic                  chip;
		logic [7:0]            red;
		logic [7:0]            green;
		logic [7:0]            blue;
		logic [5:0]            run_len;
		logic [7:0]            count_hi;
		logic [7:0]            count_lo;
	} step_row_t;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     cfg_we;
	cfg_idx_t cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lsfs_pix_if  pixel_ch ();
	lsfs_byte_if stream_ch ();

	led_strip_frame_serializer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pixel_ch),
		.stream    (stream_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow of the block's registers and frame position.
	logic [COUNT_W-1:0] shadow_count;
	logic               shadow_chip;
	logic [COUNT_W-1:0] led_pos;

	frame_byte_t frame_bytes [$];
	int          errors     = 0;
	int          words_sent = 0;
	bit          hold_req   = 1'b0;
	int          stall_cycles = 0;

	step_row_t dir_rows [NUM_DIR] = '{
		'{1'b0, 10'd0,    1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 6'd9,  8'h00, 8'h00},
		'{1'b0, 10'd0,    1'b0, 1'b0, 8'hFF, 8'hFF, 8'hFF, 6'd9,  8'h00, 8'h00},
		'{1'b1, 10'd0,    1'b0, 1'b0, 8'h55, 8'hAA, 8'h0F, 6'd9,  8'h00, 8'h00},
		'{1'b0, 10'd0,    1'b1, 1'b1, 8'hF0, 8'h3C, 8'h81, 6'd18, 8'h00, 8'h01},
		'{1'b1, 10'd3,    1'b0, 1'b0, 8'h12, 8'h34, 8'h56, 6'd14, 8'h00, 8'h03},
		'{1'b0, 10'd0,    1'b0, 1'b0, 8'hFF, 8'h00, 8'hFF, 6'd4,  8'h00, 8'h00},
		'{1'b0, 10'd0,    1'b0, 1'b0, 8'h00, 8'hFF, 8'h00, 6'd8,  8'h00, 8'h00},
		'{1'b1, 10'd1023, 1'b0, 1'b0, 8'h80, 8'h01, 8'h7E, 6'd14, 8'h02, 8'h00},
		'{1'b1, 10'd2,    1'b0, 1'b0, 8'h01, 8'h80, 8'hE7, 6'd8,  8'h00, 8'h00},
		'{1'b1, 10'd512,  1'b1, 1'b0, 8'h33, 8'hCC, 8'h99, 6'd9,  8'h01, 8'hFF},
		'{1'b0, 10'd0,    1'b1, 1'b1, 8'h66, 8'h99, 8'hC3, 6'd4,  8'h00, 8'h00},
		'{1'b1, 10'd1,    1'b0, 1'b0, 8'h0F, 8'hF0, 8'hAA, 6'd8,  8'h00, 8'h00},
		'{1'b1, 10'd513,  1'b1, 1'b0, 8'hAA, 8'h55, 8'hFF, 6'd9,  8'h01, 8'hFF},
		'{1'b1, 10'd1,    1'b0, 1'b0, 8'h7F, 8'h80, 8'h01, 6'd3,  8'h00, 8'h00},
		'{1'b1, 10'd256,  1'b0, 1'b0, 8'hFE, 8'h01, 8'h80, 6'd9,  8'h00, 8'hFF},
		'{1'b0, 10'd0,    1'b1, 1'b1, 8'hC3, 8'h3C, 8'h5A, 6'd4,  8'h00, 8'h00},
		'{1'b1, 10'd3,    1'b0, 1'b0, 8'h24, 8'h42, 8'h99, 6'd8,  8'h00, 8'h00},
		'{1'b1, 10'd256,  1'b0, 1'b0, 8'h10, 8'h20, 8'h40, 6'd14, 8'h01, 8'h00},
		'{1'b1, 10'd0,    1'b0, 1'b0, 8'h08, 8'h04, 8'h02, 6'd8,  8'h00, 8'h00},
		'{1'b1, 10'd4,    1'b1, 1'b0, 8'hDE, 8'hAD, 8'hBE, 6'd9,  8'h00, 8'h03},
		'{1'b0, 10'd0,    1'b1, 1'b1, 8'hEF, 8'hCA, 8'hFE, 6'd4,  8'h00, 8'h00},
		'{1'b0, 10'd0,    1'b1, 1'b0, 8'hBA, 8'hBE, 8'h77, 6'd3,  8'h00, 8'h00},
		'{1'b0, 10'd0,    1'b0, 1'b0, 8'h01, 8'h02, 8'h03, 6'd3,  8'h00, 8'h00}
	};

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// LEDs in a frame after the block clamps the count register.
	function automatic int frame_size();
		int n;
		n = shadow_count;
		if (n == 0)
			n = 1;
		if (n > MAX_LEDS)
			n = MAX_LEDS;
		return n;
	endfunction

	// Queues the bytes that one color word causes and returns how many there are.
	function automatic int frame_run_for_word(input led_rgb_t c, output logic [7:0] count_hi,
		output logic [7:0] count_lo);
		logic [7:0] run [$];
		int         n;
		int         hdr_count;
		int         tail;
		bit         last;
		n = frame_size();
		count_hi = 8'h00;
		count_lo = 8'h00;
		if (led_pos == 0) begin
			hdr_count = shadow_chip ? n : n - 1;
			count_hi = 8'((hdr_count >> 8) & 8'hFF);
			count_lo = 8'(hdr_count & 8'hFF);
			run.push_back(HDR_A);
			run.push_back(HDR_D);
			run.push_back(HDR_A2);
			run.push_back(count_hi);
			run.push_back(count_lo);
			run.push_back(count_hi ^ count_lo ^ HDR_SALT);
			if (shadow_chip)
				repeat (4) run.push_back(8'h00);
		end
		if (shadow_chip)
			run.push_back(LED_MARK);
		run.push_back(c.red);
		run.push_back(c.green);
		run.push_back(c.blue);
		last = (int'(led_pos) + 1) >= n;
		if (last && shadow_chip) begin
			tail = (n + 15) / 16;
			if (tail < int'(TAIL_MIN))
				tail = int'(TAIL_MIN);
			repeat (tail) run.push_back(8'h00);
		end
		foreach (run[i])
			frame_bytes.push_back('{run[i], i == run.size() - 1, last && i == run.size() - 1});
		led_pos = last ? '0 : led_pos + 1'b1;
		return run.size();
	endfunction

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_LED_COUNT)
			shadow_count = val[COUNT_W-1:0];
		else if (idx == REG_CHIP_MODE)
			shadow_chip = val[0];
		@(posedge clk);
	endtask

	task automatic pause(input int cycles);
		pixel_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Registers may only change once every queued byte has come out.
	task automatic wait_idle();
		pixel_ch.valid <= 1'b0;
		while (frame_bytes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_word(input led_rgb_t c, output int run_len, output logic [7:0] count_hi,
		output logic [7:0] count_lo);
		pixel_ch.valid <= 1'b1;
		pixel_ch.red   <= c.red;
		pixel_ch.green <= c.green;
		pixel_ch.blue  <= c.blue;
		do
			@(posedge clk);
		while (pixel_ch.ready !== 1'b1);
		run_len = frame_run_for_word(c, count_hi, count_lo);
		words_sent++;
	endtask

	initial begin : stimulus
		led_rgb_t              c;
		int                    run_len;
		logic [7:0]            count_hi;
		logic [7:0]            count_lo;
		int                    remaining;
		int                    pick;
		bit                    long_phase;
		bit                    hold_issued;
		logic [CFG_DATA_W-1:0] new_count;
		hold_issued     = 1'b0;
		shadow_count    = 10'd1;
		shadow_chip     = 1'b0;
		led_pos         = '0;
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_index       <= REG_LED_COUNT;
		cfg_data        <= '0;
		pixel_ch.valid  <= 1'b0;
		pixel_ch.red    <= '0;
		pixel_ch.green  <= '0;
		pixel_ch.blue   <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].set_count || dir_rows[i].set_chip) begin
				wait_idle();
				if (dir_rows[i].set_count)
					write_reg(REG_LED_COUNT, dir_rows[i].count);
				if (dir_rows[i].set_chip)
					write_reg(REG_CHIP_MODE, CFG_DATA_W'(dir_rows[i].chip));
			end
			c = '{dir_rows[i].red, dir_rows[i].green, dir_rows[i].blue};
			send_word(c, run_len, count_hi, count_lo);
			if (dir_rows[i].run_len != 0 && (run_len != dir_rows[i].run_len
				|| count_hi !== dir_rows[i].count_hi || count_lo !== dir_rows[i].count_lo)) begin
				errors++;
				$display("%0t: word %0d expected run %0d count %02h%02h, got run %0d count %02h%02h",
					$time, i, dir_rows[i].run_len, dir_rows[i].count_hi, dir_rows[i].count_lo,
					run_len, count_hi, count_lo);
			end
		end

		while (words_sent < TOTAL_WORDS) begin
			wait_idle();
			long_phase = !hold_issued && words_sent >= HOLD_AT;
			pick = $urandom_range(0, 9);
			if (long_phase)
				new_count = CFG_DATA_W'(64);
			else if (pick == 0)
				new_count = '0;
			else if (pick == 1)
				new_count = CFG_DATA_W'($urandom_range(40, 100));
			else
				new_count = CFG_DATA_W'($urandom_range(1, 12));
			if (long_phase || $urandom_range(0, 3) != 0)
				write_reg(REG_LED_COUNT, new_count);
			if ($urandom_range(0, 2) == 0)
				write_reg(REG_CHIP_MODE, CFG_DATA_W'($urandom_range(0, 1)));
			remaining = frame_size() - int'(led_pos);
			if (remaining < 1)
				remaining = 1;
			// Some frames are cut short so the next phase starts mid-frame.
			if (!long_phase && $urandom_range(0, 4) == 0)
				remaining = $urandom_range(1, remaining);
			if (remaining > TOTAL_WORDS - words_sent)
				remaining = TOTAL_WORDS - words_sent;
			if (long_phase) begin
				hold_req    = 1'b1;
				hold_issued = 1'b1;
			end
			repeat (remaining) begin
				c.red   = 8'($urandom_range(0, 255));
				c.green = 8'($urandom_range(0, 255));
				c.blue  = 8'($urandom_range(0, 255));
				send_word(c, run_len, count_hi, count_lo);
				if (!long_phase && words_sent < TOTAL_WORDS - QUIET_TAIL
					&& $urandom_range(0, 5) == 0)
					pause($urandom_range(1, 10));
			end
		end

		wait_idle();
		repeat (40) @(posedge clk);
		if (errors == 0 && frame_bytes.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin : byte_sink
		stream_ch.ready <= 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				// Long hold-off so the block backs up and stops taking words.
				hold_req = 1'b0;
				stream_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				stream_ch.ready <= 1'b1;
			end else if (words_sent < TOTAL_WORDS - QUIET_TAIL && $urandom_range(0, 6) == 0) begin
				stream_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				stream_ch.ready <= 1'b1;
			end else begin
				stream_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_bytes
		frame_byte_t want;
		frame_byte_t got;
		if (arst_n === 1'b1 && stream_ch.valid === 1'b1 && stream_ch.ready === 1'b1) begin
			got = '{stream_ch.byte_out, stream_ch.run_last, stream_ch.frame_end};
			if (frame_bytes.size() == 0) begin
				errors++;
				$display("%0t: expected no byte, got byte %02h last %b end %b",
					$time, got.data, got.run_last, got.frame_end);
			end else begin
				want = frame_bytes.pop_front();
				if (got.data !== want.data || got.run_last !== want.run_last
					|| got.frame_end !== want.frame_end) begin
					errors++;
					$display("%0t: expected byte %02h last %b end %b, got byte %02h last %b end %b",
						$time, want.data, want.run_last, want.frame_end,
						got.data, got.run_last, got.frame_end);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((pixel_ch.valid === 1'b1 && pixel_ch.ready === 1'b1)
			|| (stream_ch.valid === 1'b1 && stream_ch.ready === 1'b1))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

endmodule

FILE: filelist.f
hw/rtl/lsfs_pkg.sv
hw/rtl/lsfs_pix_if.sv
hw/rtl/lsfs_byte_if.sv
hw/rtl/led_strip_frame_serializer_top.sv
tb/sv/led_strip_frame_serializer_top_tb.sv
